/* rtl/core/wcm_pkg.sv */
// Package for the weighted center-line mean block: request types, the
// per-row weight table and the widths shared by the RTL.
// Depends on nothing; imported by weighted_centerline_mean_top.
package wcm_pkg;

  localparam int ROWS        = 120;
  localparam int WEIGHT_ROWS = 120;

  localparam int ROW_W  = 7;
  localparam int COL_W  = 8;
  localparam int SUM_W  = 16;
  localparam int TOT_W  = 8;
  localparam int WGT_W  = 2;

  localparam logic [COL_W-1:0] MAX_JUMP_RESET = 8'd5;

  // Weight bands of the table.
  localparam int BAND1_LO_START = 65;
  localparam int BAND1_LO_END   = 79;
  localparam int BAND2_START    = 80;
  localparam int BAND2_END      = 104;
  localparam int BAND1_HI_START = 105;
  localparam int BAND1_HI_END   = 114;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             first_row;
    logic             last_row;
  } wcm_in_t;

  typedef struct packed {
    logic [COL_W-1:0] smoothed_column;
    logic [COL_W-1:0] mean_column;
    logic             mean_valid;
    logic             frame_done;
  } wcm_out_t;

  // Weight of one image row; rows outside the table weigh nothing.
  function automatic logic [WGT_W-1:0] row_weight(logic [ROW_W-1:0] r);
    int ri;
    ri = int'(r);
    if (ri >= ROWS || ri >= WEIGHT_ROWS) begin
      return 2'd0;
    end else if (ri >= BAND2_START && ri <= BAND2_END) begin
      return 2'd2;
    end else if ((ri >= BAND1_LO_START && ri <= BAND1_LO_END) ||
                 (ri >= BAND1_HI_START && ri <= BAND1_HI_END)) begin
      return 2'd1;
    end else begin
      return 2'd0;
    end
  endfunction

endpackage

/* rtl/core/weighted_centerline_mean_top.sv */
// Top level of the weighted center-line mean block: jump limiting,
// weighted accumulation and a bit-serial divider for the frame mean.
// Depends on wcm_pkg.
//
//  channel | direction | handshake              | request content
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid / in_ready    | wcm_in_t: row, column, marks
//  out     | output    | out_valid / out_ready  | wcm_out_t: smoothed, mean
//  cfg     | input     | cfg_valid / cfg_ready  | max_jump, 8 bits
//
// A row that is not the last row of a frame is finished in the cycle it is
// accepted and its result sits in the output register on the next cycle.
// The last row of a frame with a nonzero weight sum runs the restoring
// divider, which produces one quotient bit per cycle: the block moves from
// idle to divide and then to finish, where the mean waits for a free output
// register, and takes no new request until it is back in idle.
// Input requests are taken only while the block is idle and the output
// register is empty or being drained; a stalled output holds everything.
// The synchronous reset clears the sums, the previous column and the
// control state, and restores max_jump to 5. Configuration is always ready.
module weighted_centerline_mean_top
  import wcm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wcm_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output wcm_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [COL_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [COL_W-1:0] max_jump;
  logic [COL_W-1:0] previous_column;
  logic [SUM_W-1:0] weighted_sum;
  logic [TOT_W-1:0] weight_total;

  // Divider: the dividend shifts out at the top while quotient bits shift in
  // at the bottom of the same register.
  logic [SUM_W-1:0] div_quo;
  logic [TOT_W-1:0] div_rem;
  logic [TOT_W-1:0] div_den;
  logic [3:0]       div_count;
  logic [COL_W-1:0] pend_col;

  logic             accept;
  logic             out_free;
  logic [COL_W-1:0] diff;
  logic [COL_W-1:0] col_s;
  logic [WGT_W-1:0] w;
  logic [COL_W:0]   prod;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic [TOT_W:0]   tot_ext;
  logic [TOT_W-1:0] tot_sat;
  logic             start_div;
  logic             load_direct;
  logic             load_mean;

  logic [TOT_W:0]   rem_sh;
  logic             q_bit;
  logic [TOT_W-1:0] rem_sub;
  logic [COL_W-1:0] mean_clamped;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Jump limiting against the previous smoothed column; the start row passes.
  always_comb begin
    diff = (in_data.column > previous_column) ? (in_data.column - previous_column)
                                              : (previous_column - in_data.column);
    if (!in_data.first_row && diff > max_jump) begin
      col_s = previous_column;
    end else begin
      col_s = in_data.column;
    end
  end

  // Weighted accumulation with saturation. A weight of two is a shift.
  always_comb begin
    w = row_weight(in_data.row);
    unique case (w)
      2'd0:    prod = '0;
      2'd1:    prod = {1'b0, col_s};
      default: prod = {col_s, 1'b0};
    endcase
    sum_ext = {1'b0, (in_data.first_row ? {SUM_W{1'b0}} : weighted_sum)} +
              {{(SUM_W-COL_W){1'b0}}, prod};
    sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    tot_ext = {1'b0, (in_data.first_row ? {TOT_W{1'b0}} : weight_total)} +
              {{(TOT_W-WGT_W+1){1'b0}}, w};
    tot_sat = tot_ext[TOT_W] ? '1 : tot_ext[TOT_W-1:0];
  end

  assign start_div   = accept && in_data.last_row && (tot_sat != '0);
  assign load_direct = accept && !start_div;
  assign load_mean   = (state == ST_FINISH) && out_free;

  // One restoring division step. When the quotient bit is set the
  // difference is below the divisor, so its low bits are the new remainder.
  always_comb begin
    rem_sh       = {div_rem, div_quo[SUM_W-1]};
    rem_sub      = rem_sh[TOT_W-1:0] - div_den;
    q_bit        = (rem_sh >= {1'b0, div_den});
    mean_clamped = (div_quo[SUM_W-1:COL_W] != '0) ? '1 : div_quo[COL_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_div) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_count == 4'd15) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      max_jump        <= MAX_JUMP_RESET;
      previous_column <= '0;
      weighted_sum    <= '0;
      weight_total    <= '0;
      div_count       <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_jump <= cfg_data;
      end
      if (accept) begin
        previous_column <= col_s;
        if (in_data.last_row) begin
          weighted_sum <= '0;
          weight_total <= '0;
        end else begin
          weighted_sum <= sum_sat;
          weight_total <= tot_sat;
        end
      end
      if (start_div) begin
        div_count <= '0;
      end else if (state == ST_DIVIDE) begin
        div_count <= div_count + 4'd1;
      end
      if (load_direct || load_mean) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: divider datapath and the output register.
  always_ff @(posedge clk) begin
    if (start_div) begin
      div_quo  <= sum_sat;
      div_rem  <= '0;
      div_den  <= tot_sat;
      pend_col <= col_s;
    end else if (state == ST_DIVIDE) begin
      div_quo <= {div_quo[SUM_W-2:0], q_bit};
      div_rem <= q_bit ? rem_sub : rem_sh[TOT_W-1:0];
    end
    if (load_direct) begin
      out_data.smoothed_column <= col_s;
      out_data.mean_column     <= '0;
      out_data.mean_valid      <= 1'b0;
      out_data.frame_done      <= in_data.last_row;
    end else if (load_mean) begin
      out_data.smoothed_column <= pend_col;
      out_data.mean_column     <= mean_clamped;
      out_data.mean_valid      <= 1'b1;
      out_data.frame_done      <= 1'b1;
    end
  end

endmodule
